FILE: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the page frame allocator: command and status
// codes, configuration register indexes, sequencer states and stack control.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int ADDR_W = 28;   // physical byte address
    localparam int CFG_W  = 29;   // configuration register data
    localparam int FC_W   = 17;   // free count field
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;
    localparam int CIDX_W = 1;    // configuration register index

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INC   = 2'd2,
        CMD_DEC   = 2'd3
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_BADADDR = 3'd2,
        ST_REFD    = 3'd3,
        ST_FULL    = 3'd4,
        ST_SAT     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_ALLOC = 2'd2
    } t_state;

    localparam logic [CIDX_W-1:0] CFG_KERNEL_END = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_MEM_TOP    = 1'b1;

    localparam logic [CFG_W-1:0] KERNEL_END_RST = 29'h0000_0000;
    localparam logic [CFG_W-1:0] MEM_TOP_RST    = 29'h1000_0000;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

endpackage

FILE: rtl/pfa_if.sv
// ----------------------------------------------------------------------------
// Page frame allocator channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface pfa_req_if;
    logic                        valid;
    logic                        ready;
    logic [pfa_pkg::CMD_W-1:0]   cmd;
    logic [pfa_pkg::ADDR_W-1:0]  phys_addr;

    modport source (output valid, output cmd, output phys_addr, input ready);
    modport sink   (input valid, input cmd, input phys_addr, output ready);
endinterface

interface pfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pfa_pkg::ST_W-1:0]    status;
    logic [pfa_pkg::ADDR_W-1:0]  frame_addr;
    logic [pfa_pkg::FC_W-1:0]    free_count;
    logic                        ref_zero;

    modport source (output valid, output status, output frame_addr,
                    output free_count, output ref_zero, input ready);
    modport sink   (input valid, input status, input frame_addr,
                    input free_count, input ref_zero, output ready);
endinterface

interface pfa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pfa_pkg::CIDX_W-1:0]  index;
    logic [pfa_pkg::CFG_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pfa_stack.sv
// ----------------------------------------------------------------------------
// pfa_stack
// Last-in first-out stack of free frame indices in a synchronous memory.
// The top entry is read every cycle into a register.
// ----------------------------------------------------------------------------
module pfa_stack #(
    parameter int NUM_FRAMES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pfa_pkg::t_stk_ctl                    i_ctl,
    input  logic [$clog2(NUM_FRAMES)-1:0]        i_push_data,
    output logic [$clog2(NUM_FRAMES)-1:0]        o_top,
    output logic [$clog2(NUM_FRAMES+1)-1:0]      o_depth
);

    localparam int FW = $clog2(NUM_FRAMES);
    localparam int DW = $clog2(NUM_FRAMES + 1);

    logic [FW-1:0] r_mem [NUM_FRAMES];
    logic [FW-1:0] r_top;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] w_top_idx;

    assign w_top_idx = r_depth - DW'(1);

    always_comb begin
        n_depth = r_depth;
        if (i_ctl.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_ctl.pop) begin
            n_depth = r_depth - DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_depth[FW-1:0]] <= i_push_data;
        end
        r_top <= r_mem[w_top_idx[FW-1:0]];
    end

    assign o_top   = r_top;
    assign o_depth = r_depth;

endmodule

FILE: rtl/page_frame_allocator_refcount.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount
// Page frame allocator with a free stack and per-frame reference counts.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (cmd, phys_addr): allocate, free, increment or
// decrement the reference count of a page. Each request yields one response
// on o_rsp with status, allocated frame address, free count and the
// zero-reference flag. Configuration writes on i_cfg set kernel_end (index 0)
// and mem_top (index 1); they are always accepted and are meant for idle
// periods.
// Free, increment and decrement load the response register in the execute
// state; allocate loads it in the allocate state, entered from execute, since
// the reference count of the popped frame is read after the stack top, or in
// execute when the stack is empty. The next request is taken once the
// sequencer is back in idle, so the block takes no new request before it is
// through with the last one, an order set by the registered memory reads.
// After reset the reference memory is cleared one entry per cycle; no
// request is accepted meanwhile.
// The response sits in an output register; a request is accepted while a
// response waits only if that response is taken in the same cycle, so a
// stalled receiver holds the block after at most one pending response.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
    parameter int NUM_FRAMES = 65536,
    parameter int PAGE_SHIFT = 12,
    parameter int REF_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfa_req_if.sink     i_req,
    pfa_rsp_if.source   o_rsp,
    pfa_cfg_if.sink     i_cfg
);

    localparam int AW = pfa_pkg::ADDR_W;
    localparam int CW = pfa_pkg::CFG_W;
    localparam int FC = pfa_pkg::FC_W;
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int DW = $clog2(NUM_FRAMES + 1);
    localparam logic [AW-1:0] NF_A   = AW'(NUM_FRAMES);
    localparam logic [FW-1:0] LAST_F = FW'(NUM_FRAMES - 1);
    localparam logic [DW-1:0] FULL_D = DW'(NUM_FRAMES);

    // Configuration registers.
    logic [CW-1:0] r_kernel_end;
    logic [CW-1:0] r_mem_top;

    // Sequencer and request registers.
    pfa_pkg::t_state r_state;
    pfa_pkg::t_state n_state;
    pfa_pkg::t_cmd   r_cmd;
    logic [AW-1:0]   r_addr;

    // Reference count memory and clearing sweep.
    logic [REF_WIDTH-1:0] r_ref_mem [NUM_FRAMES];
    logic [REF_WIDTH-1:0] r_ref_q;
    logic                 r_clr_busy;
    logic [FW-1:0]        r_clr_idx;

    // Response register.
    logic                 r_out_valid;
    pfa_pkg::t_status     r_out_status;
    logic [AW-1:0]        r_out_faddr;
    logic [FC-1:0]        r_out_fcount;
    logic                 r_out_rz;

    // Stack.
    pfa_pkg::t_stk_ctl    w_stk_ctl;
    logic [FW-1:0]        w_stk_top;
    logic [DW-1:0]        w_depth;

    logic                 w_req_ready;
    logic                 w_req_fire;
    logic [AW-1:0]        w_in_frame;
    logic [AW-1:0]        w_frame;
    logic                 w_in_table;
    logic                 w_bad_free;
    logic [FW-1:0]        w_ref_raddr;
    logic                 w_ref_we;
    logic [FW-1:0]        w_ref_waddr;
    logic [REF_WIDTH-1:0] w_ref_wdata;
    logic                 w_op_we;
    logic [REF_WIDTH-1:0] w_cnt;
    logic                 w_load;
    pfa_pkg::t_status     n_status;
    logic [AW-1:0]        n_faddr;
    logic [DW-1:0]        n_depth;
    logic                 n_rz;

    pfa_stack #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_stk_ctl),
        .i_push_data (w_frame[FW-1:0]),
        .o_top       (w_stk_top),
        .o_depth     (w_depth)
    );

    assign w_req_fire = i_req.valid & w_req_ready;
    assign w_in_frame = i_req.phys_addr >> PAGE_SHIFT;
    assign w_frame    = r_addr >> PAGE_SHIFT;
    assign w_in_table = w_frame < NF_A;
    assign w_bad_free = (r_addr[PAGE_SHIFT-1:0] != '0)
                      || ({1'b0, r_addr} < r_kernel_end)
                      || ({1'b0, r_addr} >= r_mem_top)
                      || !w_in_table;

    // During execution of an allocate the popped frame's count is fetched.
    assign w_ref_raddr = (r_state == pfa_pkg::S_EXEC) ? w_stk_top : w_in_frame[FW-1:0];

    assign w_ref_we    = r_clr_busy | w_op_we;
    assign w_ref_waddr = r_clr_busy ? r_clr_idx : w_frame[FW-1:0];
    assign w_ref_wdata = r_clr_busy ? '0 : w_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                if (w_req_fire) begin
                    n_state = pfa_pkg::S_EXEC;
                end
            end
            pfa_pkg::S_EXEC: begin
                if (r_cmd == pfa_pkg::CMD_ALLOC && w_depth != '0) begin
                    n_state = pfa_pkg::S_ALLOC;
                end else begin
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            pfa_pkg::S_ALLOC: begin
                n_state = pfa_pkg::S_IDLE;
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_req_ready = 1'b0;
        w_stk_ctl   = '0;
        w_op_we     = 1'b0;
        w_cnt       = r_ref_q;
        w_load      = 1'b0;
        n_status    = pfa_pkg::ST_OK;
        n_faddr     = '0;
        n_depth     = w_depth;
        n_rz        = 1'b0;
        case (r_state)
            pfa_pkg::S_IDLE: begin
                w_req_ready = !r_clr_busy && (!r_out_valid || o_rsp.ready);
            end
            pfa_pkg::S_EXEC: begin
                case (r_cmd)
                    pfa_pkg::CMD_ALLOC: begin
                        if (w_depth == '0) begin
                            n_status = pfa_pkg::ST_EMPTY;
                            w_load   = 1'b1;
                        end
                    end
                    pfa_pkg::CMD_FREE: begin
                        w_load = 1'b1;
                        if (w_bad_free) begin
                            n_status = pfa_pkg::ST_BADADDR;
                        end else if (r_ref_q != '0) begin
                            n_status = pfa_pkg::ST_REFD;
                        end else if (w_depth >= FULL_D) begin
                            n_status = pfa_pkg::ST_FULL;
                            n_rz     = 1'b1;
                        end else begin
                            w_stk_ctl.push = 1'b1;
                            n_depth        = w_depth + DW'(1);
                            n_rz           = 1'b1;
                        end
                    end
                    default: begin
                        // Increment and decrement saturate at either end.
                        w_load = 1'b1;
                        if (!w_in_table) begin
                            n_status = pfa_pkg::ST_BADADDR;
                        end else begin
                            w_op_we = 1'b1;
                            if (r_cmd == pfa_pkg::CMD_INC) begin
                                if (r_ref_q == '1) begin
                                    n_status = pfa_pkg::ST_SAT;
                                end else begin
                                    w_cnt = r_ref_q + REF_WIDTH'(1);
                                end
                            end else begin
                                if (r_ref_q == '0) begin
                                    n_status = pfa_pkg::ST_SAT;
                                end else begin
                                    w_cnt = r_ref_q - REF_WIDTH'(1);
                                end
                            end
                            n_rz = (w_cnt == '0);
                        end
                    end
                endcase
            end
            pfa_pkg::S_ALLOC: begin
                w_stk_ctl.pop = 1'b1;
                w_load        = 1'b1;
                n_depth       = w_depth - DW'(1);
                n_faddr       = AW'(w_stk_top) << PAGE_SHIFT;
                n_rz          = (r_ref_q == '0);
            end
            default: begin
                w_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + FW'(1);
                if (r_clr_idx == LAST_F) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_end <= pfa_pkg::KERNEL_END_RST;
            r_mem_top    <= pfa_pkg::MEM_TOP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pfa_pkg::CFG_KERNEL_END: r_kernel_end <= i_cfg.data;
                pfa_pkg::CFG_MEM_TOP:    r_mem_top    <= i_cfg.data;
                default: begin
                    r_kernel_end <= r_kernel_end;
                end
            endcase
        end
    end

    // Request and response payload registers.
    always_ff @(posedge i_clk) begin
        if (w_req_fire) begin
            r_cmd  <= pfa_pkg::t_cmd'(i_req.cmd);
            r_addr <= i_req.phys_addr;
        end
        if (w_load) begin
            r_out_status <= n_status;
            r_out_faddr  <= n_faddr;
            r_out_fcount <= FC'(n_depth);
            r_out_rz     <= n_rz;
        end
    end

    // Reference count memory: one read and one write port, read registered.
    always_ff @(posedge i_clk) begin
        if (w_ref_we) begin
            r_ref_mem[w_ref_waddr] <= w_ref_wdata;
        end
        r_ref_q <= r_ref_mem[w_ref_raddr];
    end

    assign i_req.ready      = w_req_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.frame_addr = r_out_faddr;
    assign o_rsp.free_count = r_out_fcount;
    assign o_rsp.ref_zero   = r_out_rz;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !w_req_fire)
        else $error("request accepted during reference table clear");

    a_fire_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_fire |=> r_state == pfa_pkg::S_EXEC)
        else $error("accepted request did not enter execution");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfa_pkg::S_ALLOC |-> w_depth != '0)
        else $error("pop from an empty free stack");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_depth <= FULL_D)
        else $error("free stack depth beyond frame count");

endmodule

FILE: tb/sv/pfa_response_checker.sv
// ----------------------------------------------------------------------------
// pfa_response_checker
// Watches the request, response and configuration channels of the page frame
// allocator, predicts each response from its own copy of the free stack,
// reference counts and address limits, and compares the responses in order.
// ----------------------------------------------------------------------------
module pfa_response_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pfa_req_if    i_req,
    pfa_rsp_if    i_rsp,
    pfa_cfg_if    i_cfg,
    output int    o_fail_count,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int NUM_FRAMES = 65536;
    localparam int PAGE_SHIFT = 12;
    localparam int REF_WIDTH  = 16;
    localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;

    typedef logic [REF_WIDTH-1:0] t_refcnt;
    localparam t_refcnt REF_MAX = '1;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  frame_addr;
        logic [FC_W-1:0]    free_count;
        logic               ref_zero;
    } t_rsp;

    t_refcnt            ref_cnt [NUM_FRAMES];
    logic [FRAME_W-1:0] free_frames [NUM_FRAMES];
    int unsigned        free_depth;
    logic [CFG_W-1:0]   kern_end;
    logic [CFG_W-1:0]   mem_top;
    t_rsp               rsp_q [$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    // Applies one command to the local copy of the allocator state.
    function automatic t_rsp predict_response(t_cmd cmd, logic [ADDR_W-1:0] addr);
        t_rsp               r;
        logic [FRAME_W-1:0] frame;
        t_refcnt            cnt;
        r = '{status: ST_OK, frame_addr: '0, free_count: '0, ref_zero: 1'b0};
        frame = addr[ADDR_W-1:PAGE_SHIFT];
        case (cmd)
            CMD_ALLOC: begin
                if (free_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    free_depth--;
                    frame = free_frames[free_depth];
                    r.frame_addr = ADDR_W'(frame) << PAGE_SHIFT;
                    r.ref_zero = (ref_cnt[frame] == 0);
                end
            end
            CMD_FREE: begin
                if (addr[PAGE_SHIFT-1:0] != 0 || addr < kern_end || addr >= mem_top) begin
                    r.status = ST_BADADDR;
                end else if (ref_cnt[frame] != 0) begin
                    r.status = ST_REFD;
                end else if (free_depth >= NUM_FRAMES) begin
                    r.status = ST_FULL;
                    r.ref_zero = 1'b1;
                end else begin
                    free_frames[free_depth] = frame;
                    free_depth++;
                    r.ref_zero = 1'b1;
                end
            end
            default: begin
                cnt = ref_cnt[frame];
                if (cmd == CMD_INC) begin
                    if (cnt == REF_MAX) r.status = ST_SAT;
                    else cnt++;
                end else begin
                    if (cnt == 0) r.status = ST_SAT;
                    else cnt--;
                end
                ref_cnt[frame] = cnt;
                r.ref_zero = (cnt == 0);
            end
        endcase
        r.free_count = FC_W'(free_depth);
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (ref_cnt[i]) ref_cnt[i] = '0;
            free_depth = 0;
            kern_end = KERNEL_END_RST;
            mem_top = MEM_TOP_RST;
            rsp_q.delete();
        end else begin
            // A response never belongs to a request accepted at the same edge,
            // so it is compared before any new request is predicted.
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_q.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    want = rsp_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("frame_addr", 32'(want.frame_addr), 32'(i_rsp.frame_addr));
                    check_field("free_count", 32'(want.free_count), 32'(i_rsp.free_count));
                    check_field("ref_zero", 32'(want.ref_zero), 32'(i_rsp.ref_zero));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_KERNEL_END) kern_end = i_cfg.data;
                else mem_top = i_cfg.data;
            end
            if (i_req.valid && i_req.ready)
                rsp_q.push_back(predict_response(t_cmd'(i_req.cmd), i_req.phys_addr));
        end
        o_outstanding = rsp_q.size();
    end

endmodule

FILE: tb/sv/page_frame_allocator_refcount_tb.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_tb
// Drives allocate, free and reference requests through the allocator under
// several address limits, with bursty requests and a stalling receiver, and
// takes the verdict from the response checker beside the block.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int                POOL_SIZE  = 24;
    localparam logic [15:0]       TAIL_FRAME = 16'h7F3C;
    localparam logic [CFG_W-1:0]  LIMIT_MAX  = 29'h1000_0000;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    bit   req_steady = 1'b0;
    bit   rsp_steady = 1'b0;
    bit   long_hold_req = 1'b0;
    int   burst_left = 4;

    pfa_req_if req_ch();
    pfa_rsp_if rsp_ch();
    pfa_cfg_if cfg_ch();

    page_frame_allocator_refcount i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    pfa_response_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #48_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: switches among random stall patterns and honors a request for
    // one long hold-off.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        bit nxt;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                hold_left = 120;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt = 1'b0;
            end else if (rsp_steady) begin
                nxt = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 64);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: nxt = 1'b1;
                    1: nxt = 1'($urandom_range(0, 1));
                    2: nxt = ($urandom_range(0, 4) != 0);
                    default: nxt = (tick % 4 == 0);
                endcase
            end
            rsp_ch.ready <= nxt;
        end
    end

    // Called at a falling edge; returns at a falling edge after acceptance, later when a burst ends.
    task automatic send_req(input t_cmd cmd, input logic [ADDR_W-1:0] addr);
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.phys_addr <= addr;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        @(negedge clk);
        burst_left--;
        if (!req_steady && burst_left <= 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Lowers the request valid and waits until every response has come back.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] kend, input logic [CFG_W-1:0] mtop);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_KERNEL_END;
        cfg_ch.data <= kend;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.index <= CFG_MEM_TOP;
        cfg_ch.data <= mtop;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] pool_addr(input int unsigned base, input bit aligned);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(base + $urandom_range(0, POOL_SIZE - 1)) << 12;
        if (!aligned && $urandom_range(0, 9) == 0) a[11:0] = 12'($urandom);
        return a;
    endfunction

    initial begin
        logic [CFG_W-1:0]  kend;
        logic [CFG_W-1:0]  mtop;
        logic [ADDR_W-1:0] page;
        int unsigned       base;
        int                sent;
        int                pick;
        bit                hold_done;
        t_cmd              cmd;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.phys_addr = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_KERNEL_END;
        cfg_ch.data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty stack, underflow, referenced free, repeated free,
        // offsets on reference requests, and the address limits.
        set_limits(KERNEL_END_RST, MEM_TOP_RST);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_DEC, 28'h000_5000);
        send_req(CMD_INC, 28'h000_5000);
        send_req(CMD_FREE, 28'h000_5000);
        send_req(CMD_DEC, 28'h000_5ABC);
        send_req(CMD_FREE, 28'h000_5000);
        send_req(CMD_FREE, 28'h000_0000);
        send_req(CMD_FREE, 28'hFFF_F000);
        send_req(CMD_FREE, 28'hFFF_F000);
        send_req(CMD_FREE, 28'h000_1001);
        send_req(CMD_INC, 28'hFFF_FFFF);
        send_req(CMD_ALLOC, 28'hFFF_FFFF);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_ALLOC, '0);
        send_req(CMD_DEC, 28'hFFF_F800);
        drain_responses();
        set_limits(LIMIT_MAX, LIMIT_MAX);
        send_req(CMD_FREE, 28'h000_0000);
        send_req(CMD_FREE, 28'hFFF_F000);
        drain_responses();
        set_limits('0, '0);
        send_req(CMD_FREE, 28'h000_0000);
        drain_responses();
        set_limits(29'h0000_3001, 29'h0000_6000);
        send_req(CMD_FREE, 28'h000_3000);
        send_req(CMD_FREE, 28'h000_4000);
        send_req(CMD_FREE, 28'h000_6000);
        send_req(CMD_FREE, 28'h000_5000);

        // Random phases, each under its own address limits.
        for (int ph = 0; ph < 5; ph++) begin
            drain_responses();
            case (ph)
                0: begin
                    kend = KERNEL_END_RST;
                    mtop = MEM_TOP_RST;
                end
                1: begin
                    kend = 29'h0100_0000;
                    mtop = 29'h0100_8000;
                end
                3: begin
                    // Window that is empty: every free is refused.
                    mtop = CFG_W'($urandom_range(0, LIMIT_MAX));
                    kend = CFG_W'($urandom_range(mtop, LIMIT_MAX));
                end
                default: begin
                    kend = CFG_W'($urandom_range(0, LIMIT_MAX));
                    mtop = CFG_W'($urandom_range(kend, LIMIT_MAX));
                end
            endcase
            set_limits(kend, mtop);
            base = kend >> 12;
            base = (base > 4) ? base - 4 : 0;
            if (base > 65536 - POOL_SIZE) base = 65536 - POOL_SIZE;
            sent = 0;
            hold_done = 1'b0;
            while (sent < 120) begin
                if (ph == 2 && !hold_done && sent >= 40) begin
                    long_hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    // Life of one page: freed, referenced, refused, released,
                    // freed again and handed out.
                    page = pool_addr(base, 1'b1);
                    send_req(CMD_FREE, page);
                    send_req(CMD_INC, page);
                    send_req(CMD_FREE, page);
                    send_req(CMD_DEC, page);
                    send_req(CMD_FREE, page);
                    send_req(CMD_ALLOC, page);
                    sent += 6;
                end else if (pick < 85) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 25) cmd = CMD_ALLOC;
                    else if (pick < 60) cmd = CMD_FREE;
                    else if (pick < 80) cmd = CMD_INC;
                    else cmd = CMD_DEC;
                    send_req(cmd, pool_addr(base, 1'b0));
                    sent++;
                end else begin
                    send_req(t_cmd'($urandom_range(0, 3)), ADDR_W'($urandom));
                    sent++;
                end
            end
        end

        // A short stretch of frees and allocates with neither side idling.
        drain_responses();
        set_limits(KERNEL_END_RST, MEM_TOP_RST);
        req_steady = 1'b1;
        rsp_steady = 1'b1;
        for (int k = 0; k < 8; k++) begin
            send_req(CMD_FREE, ADDR_W'(TAIL_FRAME + 16'(k)) << 12);
        end
        repeat (4) send_req(CMD_ALLOC, '0);
        req_steady = 1'b0;
        rsp_steady = 1'b0;

        req_ch.valid <= 1'b0;
        for (int n = 0; n < 100000 && outstanding != 0; n++) @(posedge clk);
        repeat (10) @(posedge clk);
        if (outstanding != 0) $error("%0d responses never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_stack.sv
rtl/page_frame_allocator_refcount.sv
tb/sv/pfa_response_checker.sv
tb/sv/page_frame_allocator_refcount_tb.sv
